>>> hdl/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg: shared types and constants for the prime sieve filter
// Holds the controller state encoding, the command and status bundles that
// join controller and datapath, and the fixed width of the stage field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // width of the stage number reported with each prime
  localparam int unsigned STAGE_W = 6;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_START,
    ST_DIV,
    ST_EMIT
  } pps_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // take a number into the working register
    logic clear;      // end of stream: forget all stored primes
    logic rd;         // read the table entry at the stage index
    logic div_start;  // start a remainder against the entry just read
    logic next;       // move on to the next stage
    logic emit;       // store the survivor and load the result register
  } pps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;       // stage index is below the number of stored primes
    logic div_done;   // remainder is ready
    logic rem_zero;   // remainder is zero, number is removed
    logic out_free;   // result register can take a new beat
  } pps_stat_t;

endpackage

`default_nettype wire

>>> hdl/pps_divider.sv
// ---------------------------------------------------------------------------
// pps_divider: iterative remainder unit
// Restoring shift-and-subtract, one dividend bit per cycle. A zero divisor
// leaves the dividend as the remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_divider #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                        done_o,
  output logic                        rem_zero_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH-1:0] dsr_q, dsr_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // one restoring step
  assign shifted = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = (shifted >= {1'b0, dsr_q});

  // step control
  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      rem_d = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

`default_nettype wire

>>> hdl/pps_datapath.sv
// ---------------------------------------------------------------------------
// pps_datapath: prime table, stage index and result register
// Holds the stored primes in a table with separate write and registered read,
// walks the stages under controller command and drives the output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath #(
  parameter int unsigned MAX_PRIMES  = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pps_pkg::pps_cmd_t            cmd_i,
  output pps_pkg::pps_stat_t                stat_o,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [VALUE_WIDTH-1:0]            found_prime_o,
  output logic [pps_pkg::STAGE_W-1:0]       stage_number_o,
  output logic                              table_overflow_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_PRIMES + 1);
  localparam int unsigned ADDR_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

  logic [VALUE_WIDTH-1:0] prime_mem [MAX_PRIMES];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  logic [VALUE_WIDTH-1:0] num_q;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   full;

  logic                          out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0]        out_prime_q;
  logic [pps_pkg::STAGE_W-1:0]   out_stage_q;
  logic                          out_ovf_q;

  logic div_done;
  logic rem_zero;

  assign full = (count_q == CNT_W'(MAX_PRIMES));

  // working number
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= value_i;
    end
  end

  // stage index and fill count
  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.next) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.emit && !full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  // prime table: write on store, registered read at the stage index
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && !full) begin
      prime_mem[count_q[ADDR_W-1:0]] <= num_q;
    end
    if (cmd_i.rd) begin
      rd_data_q <= prime_mem[idx_q[ADDR_W-1:0]];
    end
  end

  // shared remainder unit
  pps_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (rd_data_q),
    .done_o     (div_done),
    .rem_zero_o (rem_zero)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_prime_q <= num_q;
      out_stage_q <= full ? '0 : pps_pkg::STAGE_W'(count_q);
      out_ovf_q   <= full;
    end
  end

  // status back to the controller
  assign stat_o.more     = (idx_q < count_q);
  assign stat_o.div_done = div_done;
  assign stat_o.rem_zero = rem_zero;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign found_prime_o    = out_prime_q;
  assign stage_number_o   = out_stage_q;
  assign table_overflow_o = out_ovf_q;

endmodule

`default_nettype wire

>>> hdl/pps_ctrl.sv
// ---------------------------------------------------------------------------
// pps_ctrl: sieve sequencer
// Steps one number through the stored primes in stage order, starting a
// remainder per stage, and decides between drop, store and overflow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               end_of_stream_i,
  output logic                    in_ready_o,
  output pps_pkg::pps_cmd_t       cmd_o,
  input  wire pps_pkg::pps_stat_t stat_i
);

  pps_pkg::pps_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_valid_i && !end_of_stream_i) begin
          state_d = pps_pkg::ST_TEST;
        end
      end
      pps_pkg::ST_TEST: begin
        state_d = stat_i.more ? pps_pkg::ST_START : pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_START: begin
        state_d = pps_pkg::ST_DIV;
      end
      pps_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = stat_i.rem_zero ? pps_pkg::ST_IDLE : pps_pkg::ST_TEST;
        end
      end
      pps_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = pps_pkg::ST_IDLE;
        end
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i && !end_of_stream_i;
        cmd_o.clear = in_valid_i && end_of_stream_i;
      end
      pps_pkg::ST_TEST: begin
        cmd_o.rd = stat_i.more;
      end
      pps_pkg::ST_START: begin
        cmd_o.div_start = 1'b1;
      end
      pps_pkg::ST_DIV: begin
        cmd_o.next = stat_i.div_done && !stat_i.rem_zero;
      end
      pps_pkg::ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pipelined_prime_sieve_filter.sv
// A number is tested stage by stage against the n primes stored, each stage
// reading the table and running a remainder; a number removed early stops
// at its dividing stage. One number is in flight at a time, so a new number
// is taken only once the last one is dropped or emitted, as the bit-serial
// remainder unit is shared. An end-of-stream beat clears the table from idle.
// Reset (rst_ni low, asynchronous) empties the table and the result register.
// ---------------------------------------------------------------------------
// pipelined_prime_sieve_filter: streaming prime sieve
// Tests each number against the stored primes in stage order and stores
// and emits the survivors; a survivor with the table full is flagged.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pipelined_prime_sieve_filter #(
  parameter int unsigned MAX_PRIMES  = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  input  wire logic                         end_of_stream_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [VALUE_WIDTH-1:0]            found_prime_o,
  output logic [pps_pkg::STAGE_W-1:0]       stage_number_o,
  output logic                              table_overflow_o
);

  pps_pkg::pps_cmd_t  cmd;
  pps_pkg::pps_stat_t stat;

  // sequencer
  pps_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .end_of_stream_i (end_of_stream_i),
    .in_ready_o      (in_ready_o),
    .cmd_o           (cmd),
    .stat_i          (stat)
  );

  // table, divider and result register
  pps_datapath #(
    .MAX_PRIMES  (MAX_PRIMES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_prime_o    (found_prime_o),
    .stage_number_o   (stage_number_o),
    .table_overflow_o (table_overflow_o)
  );

endmodule

`default_nettype wire

>>> hdl/pps_checker.sv
// ---------------------------------------------------------------------------
// pps_checker: port-level checks for the prime sieve filter
// Watches the top-level handshakes and the sequencing they imply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_checker #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [VALUE_WIDTH-1:0]       value_i,
  input wire logic                         end_of_stream_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [VALUE_WIDTH-1:0]       found_prime_o,
  input wire logic [pps_pkg::STAGE_W-1:0]  stage_number_o,
  input wire logic                         table_overflow_o
);

  // a waiting input beat is held unchanged until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(value_i)
      && $stable(end_of_stream_i)))
    else $error("input beat dropped or changed while stalled");

  // a pending result beat is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(found_prime_o)
      && $stable(stage_number_o) && $stable(table_overflow_o)))
    else $error("result beat dropped or changed while stalled");

  // a number beat occupies the sieve, so input closes next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !end_of_stream_i) |=> !in_ready_o)
    else $error("input still open while a number is being sieved");

  // end of stream completes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_stream_i) |=> in_ready_o)
    else $error("end of stream beat held the input closed");

  // a new result only appears at the end of sieving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat appeared without a number being sieved");

endmodule

bind pipelined_prime_sieve_filter pps_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_pps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .value_i          (value_i),
  .end_of_stream_i  (end_of_stream_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .found_prime_o    (found_prime_o),
  .stage_number_o   (stage_number_o),
  .table_overflow_o (table_overflow_o)
);

`default_nettype wire
